// ===== hw/rtl/isrs_pkg.sv =====
// ----------------------------------------------------------------------------
// isrs_pkg: shared types and constants of the I2C serial RAM slave
// Item structs, bus event codes, address phase codes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package isrs_pkg;

  // Fixed field widths
  localparam int PTR_W  = 16;
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 17;

  // Sizes above this take a two-byte address
  localparam int SINGLE_ADDR_LIMIT = 256;

  // Remainder unit: pointer bits retired per cycle and steps per item
  localparam int DIV_BITS_PER_STEP = 2;
  localparam int DIV_STEPS         = PTR_W / DIV_BITS_PER_STEP;
  localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

  // Bus event codes
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_STOP  = 2'd1,
    REQ_RX    = 2'd2,
    REQ_TX    = 2'd3
  } req_e;

  // Address phase codes
  typedef enum logic [1:0] {
    PH_ADDR_HI = 2'd0,
    PH_ADDR_LO = 2'd1,
    PH_DATA    = 2'd2,
    PH_IDLE    = 2'd3
  } phase_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [BYTE_W-1:0] data_in;
  } isrs_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
  } isrs_out_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;
    logic capture;
    logic ev_apply;
    logic div_start;
    logic div_step;
    logic mem_acc;
    logic out_load;
  } isrs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_done;
    logic need_access;
    logic div_last;
  } isrs_stat_t;

endpackage

// ===== hw/rtl/isrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// isrs_ctrl: sequencing state machine of the I2C serial RAM slave
// Runs the clearing sweep, takes one item at a time, steps the remainder
// unit and the memory access, and owns the result valid flag.
// ----------------------------------------------------------------------------
module isrs_ctrl
  import isrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  isrs_stat_t stat_i,
  output isrs_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_DECODE = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_MEM    = 6'b010000,
    ST_RESP   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.need_access) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          cmd_o.ev_apply = 1'b1;
          state_d        = ST_RESP;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_MEM;
        end
      end
      ST_MEM: begin
        cmd_o.mem_acc = 1'b1;
        state_d       = ST_RESP;
      end
      ST_RESP: begin
        // hold until the output register is free or drains this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/isrs_dpath.sv =====
// ----------------------------------------------------------------------------
// isrs_dpath: datapath of the I2C serial RAM slave
// Size register, address pointer and phase, the radix-4 remainder unit,
// the byte memory with its clearing sweep, and the result register.
// ----------------------------------------------------------------------------
module isrs_dpath
  import isrs_pkg::*;
#(
  parameter int MEM_DEPTH = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  isrs_cmd_t        cmd_i,
  output isrs_stat_t       stat_o,
  input  isrs_in_t         in_item_i,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  output isrs_out_t        out_item_o
);

  localparam int AW = $clog2(MEM_DEPTH);
  localparam int SW = $clog2(MEM_DEPTH + 1);

  logic [BYTE_W-1:0] mem_q [MEM_DEPTH];

  logic [SW-1:0]     size_q, size_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  phase_e            phase_q, phase_d;
  logic [AW-1:0]     clr_cnt_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [SW-1:0]     rem_q, rem_d;
  logic [PTR_W-1:0]  sh_q;
  logic [1:0]        req_q;
  logic [BYTE_W-1:0] data_q;
  logic [BYTE_W-1:0] rd_q;
  isrs_out_t         out_q;

  logic              two_byte;
  logic              is_write;
  logic [SW-1:0]     nxt_ptr;

  assign two_byte = (size_q > SW'(SINGLE_ADDR_LIMIT));
  assign is_write = (req_q == REQ_RX);

  // Clamp a written size to 1..MEM_DEPTH
  always_comb begin
    size_d = size_q;
    if (cfg_we_i) begin
      if (cfg_data_i == '0) begin
        size_d = SW'(1);
      end else if (cfg_data_i > CFG_W'(MEM_DEPTH)) begin
        size_d = SW'(MEM_DEPTH);
      end else begin
        size_d = SW'(cfg_data_i);
      end
    end
  end

  // Two restoring remainder steps per cycle, pointer bits MSB first
  always_comb begin
    logic [SW:0]   trial;
    logic [SW-1:0] r;
    r = rem_q;
    for (int k = 0; k < DIV_BITS_PER_STEP; k++) begin
      trial = {r, sh_q[PTR_W-1-k]};
      if (trial >= {1'b0, size_q}) begin
        r = SW'(trial - {1'b0, size_q});
      end else begin
        r = trial[SW-1:0];
      end
    end
    rem_d = r;
  end

  // Advance the pointer past the accessed entry, wrapping at the size
  always_comb begin
    nxt_ptr = rem_q + SW'(1);
    if (nxt_ptr >= size_q) begin
      nxt_ptr = '0;
    end
  end

  // Pointer and phase updates
  always_comb begin
    ptr_d   = ptr_q;
    phase_d = phase_q;
    if (cmd_i.ev_apply) begin
      case (req_q)
        REQ_START: phase_d = two_byte ? PH_ADDR_HI : PH_ADDR_LO;
        REQ_STOP:  phase_d = PH_IDLE;
        REQ_RX: begin
          if (phase_q == PH_ADDR_HI) begin
            phase_d = PH_ADDR_LO;
            ptr_d   = {data_q, {BYTE_W{1'b0}}};
          end else begin
            phase_d = PH_DATA;
            ptr_d   = two_byte ? PTR_W'(ptr_q + {{(PTR_W-BYTE_W){1'b0}}, data_q})
                               : {{(PTR_W-BYTE_W){1'b0}}, data_q};
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end else if (cmd_i.mem_acc) begin
      ptr_d = PTR_W'(nxt_ptr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q    <= SW'(MEM_DEPTH);
      ptr_q     <= '0;
      phase_q   <= PH_IDLE;
      clr_cnt_q <= '0;
      div_cnt_q <= '0;
    end else begin
      size_q  <= size_d;
      ptr_q   <= ptr_d;
      phase_q <= phase_d;
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      end
    end
  end

  // Item capture, remainder registers and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= in_item_i.req_type;
      data_q <= in_item_i.data_in;
    end
    if (cmd_i.div_start) begin
      rem_q <= '0;
      sh_q  <= ptr_q;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      sh_q  <= sh_q << DIV_BITS_PER_STEP;
    end
    if (cmd_i.out_load) begin
      out_q.data_out   <= (req_q == REQ_TX) ? rd_q : '0;
      out_q.data_valid <= (req_q == REQ_TX);
    end
  end

  // Byte memory: one port, clearing sweep or item access
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (cmd_i.mem_acc && is_write) begin
      mem_q[rem_q[AW-1:0]] <= data_q;
    end
    if (cmd_i.mem_acc && !is_write) begin
      rd_q <= mem_q[rem_q[AW-1:0]];
    end
  end

  assign stat_o.clr_done    = (clr_cnt_q == AW'(MEM_DEPTH - 1));
  assign stat_o.need_access = (req_q == REQ_TX) ||
                              ((req_q == REQ_RX) && (phase_q inside {PH_DATA, PH_IDLE}));
  assign stat_o.div_last    = (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign out_item_o         = out_q;

endmodule

// ===== hw/rtl/i2c_serial_ram_slave.sv =====
// ----------------------------------------------------------------------------
// i2c_serial_ram_slave: byte-level memory side of a 24Cxx-style serial RAM
// Takes start, stop, received and requested byte events, loads the address
// pointer, and writes or reads the byte memory at the pointer reduced
// modulo the size in use.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------
//  in       | input     | in_valid_i / in_stall_o | in_item_i  (isrs_in_t)
//  out      | output    | out_valid_o/out_stall_i | out_item_o (isrs_out_t)
//  cfg      | input     | cfg_we_i                | cfg_data_i (size_bytes)
//
//  One item at a time. Start, stop and address bytes pass through decode
//  and response; data reads and writes also pass through the remainder unit,
//  two pointer bits per step, and then the memory port.
//  After reset the memory is swept to zero, entry by entry, during
//  which no item is accepted; configuration writes are taken throughout.
//  A result waits in the output register while the next item is accepted;
//  a stalled output holds the block only when a further result is ready.
//
module i2c_serial_ram_slave
  import isrs_pkg::*;
#(
  parameter int MEM_DEPTH = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  isrs_in_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output isrs_out_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  isrs_cmd_t  cmd;
  isrs_stat_t stat;

  // Sequence the item
  isrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Hold pointer, memory and result
  isrs_dpath #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .in_item_i  (in_item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .out_item_o (out_item_o)
  );

endmodule

// ===== hw/rtl/isrs_checker.sv =====
// ----------------------------------------------------------------------------
// isrs_checker: port-level checks of the I2C serial RAM slave
// Watches the top level's ports and flags handshake and sequencing slips.
// ----------------------------------------------------------------------------
module isrs_checker
  import isrs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input isrs_in_t         in_item_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input isrs_out_t        out_item_o,
  input logic             cfg_we_i,
  input logic [CFG_W-1:0] cfg_data_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Hold a stalled input item until it is taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input item changed");

  // Take one item at a time: stall straight after an acceptance
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item accepted while busy");

  // Raise a result only from an item at work
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no item at work");

  // Write the size register only with known data
  a_cfg_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !$isunknown(cfg_data_i))
    else $error("size written with unknown data");

endmodule

bind i2c_serial_ram_slave isrs_checker u_isrs_checker (.*);

// ===== tb/sv/i2c_serial_ram_slave_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_serial_ram_slave_tb: self-checking bench for the serial RAM slave
// Drives start, stop, received and requested byte events, mirrors the
// address pointer, phase and byte store in a local model, and checks every
// result item in order. Sweeps the memory size through its extremes, with
// random idling on both channels and a final unthrottled stretch.
// ----------------------------------------------------------------------------
module i2c_serial_ram_slave_tb;
  import isrs_pkg::*;

  localparam int MEM_DEPTH       = 65536;
  localparam int SETTLE_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT  = 200000;
  localparam int MAX_REPORTS     = 10;

  // Clock and block inputs, all known from time zero
  logic             clk_i    = 1'b0;
  logic             rst_n    = 1'b0;
  logic             in_valid = 1'b0;
  isrs_in_t         in_item  = '0;
  logic             out_stall = 1'b0;
  logic             cfg_we   = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  logic             in_stall_o;
  logic             out_valid_o;
  isrs_out_t        out_item_o;

  // Local copy of the block state
  logic [7:0]       mem_model [0:MEM_DEPTH-1];
  logic [PTR_W-1:0] ptr_model;
  phase_e           phase_model;
  int unsigned      size_model;

  isrs_out_t        read_results_q [$];

  bit               idle_en = 1'b1;
  int               out_stall_left = 0;
  int               idle_cycles = 0;
  int               errors = 0;
  int               items_sent = 0;
  int               reads_checked = 0;
  int               size_settings = 0;

  i2c_serial_ram_slave u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Advance the pointer past an access, wrapping at the size in use
  function automatic logic [PTR_W-1:0] next_pointer(input int unsigned idx);
    int unsigned n;
    n = idx + 1;
    if (n >= size_model) n = 0;
    return n[PTR_W-1:0];
  endfunction

  // Apply one bus event to the local state and return its result item
  function automatic isrs_out_t predict_ram_access(input isrs_in_t it);
    isrs_out_t   res;
    int unsigned idx;
    res = '0;
    case (it.req_type)
      REQ_START: begin
        phase_model = (size_model > SINGLE_ADDR_LIMIT) ? PH_ADDR_HI : PH_ADDR_LO;
      end
      REQ_STOP: begin
        phase_model = PH_IDLE;
      end
      REQ_RX: begin
        if (phase_model == PH_ADDR_HI) begin
          phase_model = PH_ADDR_LO;
          ptr_model   = {it.data_in, 8'h00};
        end else if (phase_model == PH_ADDR_LO) begin
          phase_model = PH_DATA;
          if (size_model > SINGLE_ADDR_LIMIT) ptr_model = ptr_model + it.data_in;
          else ptr_model = {8'h00, it.data_in};
        end else begin
          idx            = ptr_model % size_model;
          mem_model[idx] = it.data_in;
          ptr_model      = next_pointer(idx);
        end
      end
      default: begin
        idx            = ptr_model % size_model;
        res.data_out   = mem_model[idx];
        res.data_valid = 1'b1;
        ptr_model      = next_pointer(idx);
      end
    endcase
    return res;
  endfunction

  // Send one item, with an optional idle burst ahead of it
  task automatic send_item(input req_e req, input logic [7:0] data);
    isrs_in_t it;
    it.req_type = req;
    it.data_in  = data;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    read_results_q.push_back(predict_ram_access(it));
    items_sent++;
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (read_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the size register while idle and track the clamped value
  task automatic write_size(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    if (value == 0) size_model = 1;
    else if (value > MEM_DEPTH) size_model = MEM_DEPTH;
    else size_model = value;
    size_settings++;
  endtask

  // Start, then one or two address bytes depending on the size in use
  task automatic send_address(input int unsigned addr);
    send_item(REQ_START, 8'($urandom));
    if (size_model > SINGLE_ADDR_LIMIT) send_item(REQ_RX, addr[15:8]);
    send_item(REQ_RX, addr[7:0]);
  endtask

  // Mostly well-formed transfers with random content, the rest noise
  task automatic random_transaction();
    int unsigned kind;
    int unsigned addr;
    int unsigned len;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      repeat ($urandom_range(1, 4)) send_item(req_e'(2'($urandom_range(0, 3))), 8'($urandom));
    end else begin
      if ($urandom_range(0, 6) == 0) addr = $urandom_range(0, 65535);
      else addr = $urandom_range(0, size_model - 1);
      len = $urandom_range(1, 8);
      send_address(addr);
      if (kind < 7) begin
        // write a burst, then re-address and read it back
        repeat (len) send_item(REQ_RX, 8'($urandom));
        if ($urandom_range(0, 3) == 0) send_item(REQ_STOP, 8'($urandom));
        send_address(addr);
        repeat (len) send_item(REQ_TX, 8'($urandom));
      end else if (kind < 9) begin
        repeat (len) send_item(REQ_TX, 8'($urandom));
      end else begin
        repeat (len) send_item($urandom_range(0, 1) ? REQ_RX : REQ_TX, 8'($urandom));
      end
      if ($urandom_range(0, 9) != 0) send_item(REQ_STOP, 8'($urandom));
    end
  endtask

  task automatic run_items(input int count);
    int target;
    target = items_sent + count;
    while (items_sent < target) random_transaction();
  endtask

  // Reads and writes straight after reset, with no start seen yet
  task automatic test_access_after_reset();
    send_item(REQ_TX, 8'h00);
    send_item(REQ_RX, 8'hA5);
    send_item(REQ_START, 8'hFF);
    // a read while the high address byte is awaited
    send_item(REQ_TX, 8'h00);
  endtask

  // Two-byte addressing at the top of the store and wrap to zero
  task automatic test_two_byte_wrap();
    send_item(REQ_RX, 8'hFF);
    send_item(REQ_RX, 8'hFF);
    send_item(REQ_RX, 8'h00);
    send_item(REQ_RX, 8'h5A);
    send_address(16'hFFFF);
    send_item(REQ_TX, 8'hFF);
    send_item(REQ_TX, 8'h00);
    send_item(REQ_STOP, 8'h00);
  endtask

  // Size clamping, one-byte addressing and pointers beyond the size
  task automatic test_size_limits();
    write_size('0);
    send_address(8'h80);
    send_item(REQ_RX, 8'h33);
    send_item(REQ_TX, 8'h00);
    write_size(17'd256);
    send_address(8'hFF);
    send_item(REQ_TX, 8'h00);
    // change size with a transfer still open
    write_size(17'd257);
    send_address(16'h0102);
    send_item(REQ_TX, 8'h00);
    write_size(17'h1FFFF);
  endtask

  // Random traffic across a sweep of sizes
  task automatic test_random_traffic();
    logic [CFG_W-1:0] sweep [$];
    sweep = '{17'd65536, 17'd1, 17'd2, 17'd16, 17'd255, 17'd256, 17'd257, 17'd300,
              17'd4096, 17'd65535, 17'd0, 17'h1FFFF, 17'($urandom_range(3, 131071))};
    foreach (sweep[i]) begin
      write_size(sweep[i]);
      if (i == 4) begin
        run_items(55);
        drain_results();
        run_items(55);
      end else begin
        run_items(110);
      end
    end
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_unthrottled_traffic();
    idle_en = 1'b0;
    write_size(17'd512);
    run_items(120);
  endtask

  // Random stall bursts on the result channel
  always @(posedge clk_i) begin
    if (out_stall_left > 0) begin
      out_stall <= 1'b1;
      out_stall_left--;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      out_stall_left = $urandom_range(1, 10) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    isrs_out_t exp_item;
    if (rst_n && out_valid_o === 1'b1 && !out_stall) begin
      if (read_results_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: data_out %02h data_valid %0b",
                   out_item_o.data_out, out_item_o.data_valid);
      end else begin
        exp_item = read_results_q.pop_front();
        if (out_item_o.data_out !== exp_item.data_out ||
            out_item_o.data_valid !== exp_item.data_valid) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch: data_out exp %02h got %02h, data_valid exp %0b got %0b",
                     exp_item.data_out, out_item_o.data_out,
                     exp_item.data_valid, out_item_o.data_valid);
        end else if (exp_item.data_valid) begin
          reads_checked++;
        end
      end
    end
  end

  // Drop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MEM_DEPTH; i++) mem_model[i] = '0;
    ptr_model   = '0;
    phase_model = PH_IDLE;
    size_model  = MEM_DEPTH;
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;

    test_access_after_reset();
    test_two_byte_wrap();
    test_size_limits();
    test_random_traffic();
    test_unthrottled_traffic();

    drain_results();
    if (read_results_q.size() != 0) begin
      errors += read_results_q.size();
      $display("%0d expected results never arrived", read_results_q.size());
    end
    $display("Covered %0d bus events, %0d of them byte reads checked, over %0d size settings.",
             items_sent, reads_checked, size_settings);
    $display("Sizes ran from 1 to %0d bytes, with idling on both channels, then none.",
             MEM_DEPTH);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/isrs_pkg.sv
hw/rtl/isrs_ctrl.sv
hw/rtl/isrs_dpath.sv
hw/rtl/i2c_serial_ram_slave.sv
hw/rtl/isrs_checker.sv
tb/sv/i2c_serial_ram_slave_tb.sv
